// File: sv/multi_sensor_echo_ranger_assert.svh
// ----------------------------------------------------------------------------
// echo ranger assertion macros
// concurrent checks clocked on clk, masked while arst_n is low
// ----------------------------------------------------------------------------
`ifndef MULTI_SENSOR_ECHO_RANGER_ASSERT_SVH
`define MULTI_SENSOR_ECHO_RANGER_ASSERT_SVH

// same-cycle implication
`define MSER_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSER_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/mser_pkg.sv
// ----------------------------------------------------------------------------
// mser_pkg
// types and constants of the multi-sensor echo ranger
// ----------------------------------------------------------------------------
package mser_pkg;

	typedef enum logic [1:0] {
		KIND_CAPTURE  = 2'd0,
		KIND_TRIGGER  = 2'd1,
		KIND_TIMEOUT  = 2'd2,
		KIND_RESERVED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_GROUP_MASK_0 = 2'd0,
		REG_GROUP_MASK_1 = 2'd1,
		REG_GROUP_MASK_2 = 2'd2,
		REG_GROUP_COUNT  = 2'd3
	} cfg_reg_t;

	localparam int MASK_W      = 6;
	localparam int SENSOR_W    = 3;
	localparam int TS_W        = 16;
	localparam int DIST_W      = 24;
	localparam int TALLY_W     = 16;
	localparam int GROUP_W     = 2;
	localparam int CFG_DATA_W  = 6;
	localparam int IN_DATA_W   = 24;

	// at most three mask registers exist
	localparam logic [GROUP_W-1:0] GROUP_LIMIT = 2'd3;

	localparam logic [DIST_W-1:0]  FAR_DISTANCE = 24'd5100000;
	localparam logic [7:0]         UM_PER_COUNT = 8'd170;
	localparam logic [TALLY_W-1:0] TALLY_MAX    = 16'hFFFF;

	localparam logic [MASK_W-1:0] RST_MASK_0 = 6'd41;
	localparam logic [MASK_W-1:0] RST_MASK_1 = 6'd18;
	localparam logic [MASK_W-1:0] RST_MASK_2 = 6'd4;
	localparam logic [GROUP_W-1:0] RST_GROUP_COUNT = 2'd3;

	// packed msb first, so measured lands in bit 0 of tdata
	typedef struct packed {
		logic [GROUP_W-1:0] group_index;
		logic               group_done;
		logic [MASK_W-1:0]  timeout_mask;
		logic [MASK_W-1:0]  trigger_mask;
		logic [TALLY_W-1:0] timeout_total;
		logic [DIST_W-1:0]  distance_um;
		logic               measured;
	} result_t;

endpackage

// File: sv/multi_sensor_echo_ranger.sv
// ----------------------------------------------------------------------------
// multi_sensor_echo_ranger
// echo pulse-width ranging controller with round-robin sensor groups
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the output side takes results and
// returns exactly one result transaction for each. A transaction is
// registered at the input, evaluated against the per-sensor registers and
// placed in the output register when that register is free or being read,
// so the sustained rate is one transaction per cycle while the output side
// takes results. The only loop-carried path is the per-sensor state update
// (one 16-bit subtract and one multiply by 170). Group masks and the group
// count come from the write port and should change only while the block is
// idle.
module multi_sensor_echo_ranger #(
	parameter int SENSORS = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [2:0] sensor, [18:3] timestamp, [23:19] zero
	input  logic [mser_pkg::IN_DATA_W-1:0] s_tdata,
	// [1:0] kind
	input  logic [1:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [0] measured, [24:1] distance_um, [40:25] timeout_total,
	// [46:41] trigger_mask, [52:47] timeout_mask, [53] group_done,
	// [55:54] group_index
	output logic [$bits(mser_pkg::result_t)-1:0] m_tdata,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [mser_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mser_pkg::*;

	// sensor field is three bits, so no more than eight can be addressed
	localparam int NS    = (SENSORS < 8) ? SENSORS : 8;
	localparam int IDX_W = (NS > 1) ? $clog2(NS) : 1;
	localparam logic [MASK_W-1:0] SENSOR_BITS =
		(SENSORS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << SENSORS) - 1);

	// configuration
	logic [MASK_W-1:0]  mask0_q, mask1_q, mask2_q;
	logic [GROUP_W-1:0] gcount_q;

	// per-sensor state
	logic               phase_q [NS];
	logic [TS_W-1:0]    start_q [NS];
	logic [DIST_W-1:0]  dist_q  [NS];
	logic [TALLY_W-1:0] tally_q [NS];
	logic [MASK_W-1:0]  waiting_q;
	logic [GROUP_W-1:0] group_q;

	logic               phase_d [NS];
	logic [TS_W-1:0]    start_d [NS];
	logic [DIST_W-1:0]  dist_d  [NS];
	logic [TALLY_W-1:0] tally_d [NS];
	logic [MASK_W-1:0]  waiting_d;
	logic [GROUP_W-1:0] group_d;

	// input stage
	logic                vld_s1;
	kind_t               kind_s1;
	logic [SENSOR_W-1:0] sensor_s1;
	logic [TS_W-1:0]     ts_s1;

	// output register
	logic    out_vld_q;
	result_t res_q;
	result_t res_d;

	logic                adv_s1;
	logic                fire_s1;
	logic                sensor_ok;
	logic [IDX_W-1:0]    idx;
	logic [GROUP_W-1:0]  n_groups;
	logic [GROUP_W-1:0]  cur_grp;
	logic [GROUP_W-1:0]  grp_next;
	logic [MASK_W-1:0]   grp_mask;
	logic [7:0]          waiting_ext;
	logic [15:0]         timeout_ext;
	logic [TS_W-1:0]     width;
	logic [DIST_W-1:0]   width_um;

	assign adv_s1   = !out_vld_q || m_tready;
	assign fire_s1  = vld_s1 && adv_s1;
	assign s_tready = !vld_s1 || adv_s1;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask0_q  <= RST_MASK_0;
			mask1_q  <= RST_MASK_1;
			mask2_q  <= RST_MASK_2;
			gcount_q <= RST_GROUP_COUNT;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GROUP_MASK_0: mask0_q  <= cfg_data;
				REG_GROUP_MASK_1: mask1_q  <= cfg_data;
				REG_GROUP_MASK_2: mask2_q  <= cfg_data;
				REG_GROUP_COUNT:  gcount_q <= cfg_data[GROUP_W-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1   <= kind_t'(s_tuser);
			sensor_s1 <= s_tdata[SENSOR_W-1:0];
			ts_s1     <= s_tdata[SENSOR_W +: TS_W];
		end
	end

	always_comb begin
		n_groups = (gcount_q > GROUP_LIMIT) ? GROUP_LIMIT : gcount_q;
		sensor_ok = ({1'b0, sensor_s1} < (SENSOR_W+1)'(NS));
		idx = sensor_s1[IDX_W-1:0];
		waiting_ext = {{(8-MASK_W){1'b0}}, waiting_q};
		timeout_ext = 16'(waiting_q);
		// a wrapped index restarts at group zero before triggering
		cur_grp = (group_q >= n_groups) ? '0 : group_q;
		case (cur_grp)
			2'd0:    grp_mask = mask0_q;
			2'd1:    grp_mask = mask1_q;
			2'd2:    grp_mask = mask2_q;
			default: grp_mask = '0;
		endcase
		width    = ts_s1 - start_q[idx];
		width_um = DIST_W'({8'd0, width} * {16'd0, UM_PER_COUNT});

		phase_d   = phase_q;
		start_d   = start_q;
		dist_d    = dist_q;
		tally_d   = tally_q;
		waiting_d = waiting_q;
		group_d   = group_q;
		grp_next  = '0;
		res_d     = '0;

		case (kind_s1)
			KIND_CAPTURE: begin
				if (sensor_ok) begin
					if (!phase_q[idx]) begin
						start_d[idx] = ts_s1;
						phase_d[idx] = 1'b1;
					end else begin
						dist_d[idx]    = width_um;
						phase_d[idx]   = 1'b0;
						res_d.measured = 1'b1;
						if (waiting_ext[sensor_s1]) begin
							waiting_d = waiting_q & ~MASK_W'(8'd1 << sensor_s1);
							if (waiting_d == '0) begin
								grp_next = group_q + 2'd1;
								group_d  = (grp_next >= n_groups) ? '0 : grp_next;
								res_d.group_done = 1'b1;
							end
						end
					end
				end
			end
			KIND_TRIGGER: begin
				if (n_groups != '0) begin
					group_d   = cur_grp;
					waiting_d = grp_mask & SENSOR_BITS;
					res_d.trigger_mask = grp_mask & SENSOR_BITS;
					if ((grp_mask & SENSOR_BITS) == '0) begin
						// empty group finishes at once
						grp_next = cur_grp + 2'd1;
						group_d  = (grp_next >= n_groups) ? '0 : grp_next;
						res_d.group_done = 1'b1;
					end
				end
			end
			KIND_TIMEOUT: begin
				if (waiting_q != '0) begin
					for (int i = 0; i < NS; i++) begin
						if (timeout_ext[i]) begin
							if (tally_q[i] != TALLY_MAX)
								tally_d[i] = tally_q[i] + 16'd1;
							phase_d[i] = 1'b0;
							start_d[i] = '0;
							dist_d[i]  = FAR_DISTANCE;
						end
					end
					res_d.timeout_mask = waiting_q;
					waiting_d = '0;
					grp_next  = group_q + 2'd1;
					group_d   = (grp_next >= n_groups) ? '0 : grp_next;
					res_d.group_done = 1'b1;
				end
			end
			default: ;
		endcase

		if (sensor_ok) begin
			res_d.distance_um   = dist_d[idx];
			res_d.timeout_total = tally_d[idx];
		end
		res_d.group_index = group_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				phase_q[i] <= 1'b0;
				start_q[i] <= '0;
				dist_q[i]  <= FAR_DISTANCE;
				tally_q[i] <= '0;
			end
			waiting_q <= '0;
			group_q   <= '0;
		end else if (fire_s1) begin
			phase_q   <= phase_d;
			start_q   <= start_d;
			dist_q    <= dist_d;
			tally_q   <= tally_d;
			waiting_q <= waiting_d;
			group_q   <= group_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_q <= res_d;
		end
	end

	`include "multi_sensor_echo_ranger_assert.svh"

	`MSER_ASSERT_IMP(a_timeout_done, out_vld_q && (res_q.timeout_mask != '0), res_q.group_done, "timeout without group advance")
	`MSER_ASSERT_IMP(a_trigger_wait, out_vld_q && (res_q.trigger_mask != '0), !res_q.group_done, "nonempty trigger advanced group")
	`MSER_ASSERT_IMP(a_measure_kind, out_vld_q && res_q.measured, (res_q.trigger_mask == '0) && (res_q.timeout_mask == '0), "measurement mixed with group event")
	`MSER_ASSERT_NXT(a_timeout_clear, fire_s1 && (kind_s1 == KIND_TIMEOUT), waiting_q == '0, "waiting mask not cleared by timeout")

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the six-channel echo ranger: a directed table walks
// edge captures, triggers, timeouts and group configurations, then random
// trigger / capture / timeout traffic runs under several group settings;
// every result transaction is compared field by field with a local model of
// the ranger or with expected values from the directed table, with random idle cycles on both stream sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import mser_pkg::*;

	localparam int NUM_SENSORS    = 6;
	localparam logic [MASK_W-1:0] ALL_SENSORS = 6'h3F;
	localparam int PHASE_ITEMS    = 135;
	localparam int RAND_PHASES    = 8;
	localparam int WATCHDOG_LIMIT = 500;

	typedef struct {
		bit                 is_cfg;
		logic [1:0]         code;
		logic [2:0]         sensor;
		logic [15:0]        value;
		bit                 typed;
		result_t            want;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// [2:0] sensor, [18:3] timestamp, [23:19] zero
	logic [IN_DATA_W-1:0]   s_tdata;
	// [1:0] kind
	logic [1:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// [0] measured, [24:1] distance_um, [40:25] timeout_total,
	// [46:41] trigger_mask, [52:47] timeout_mask, [53] group_done,
	// [55:54] group_index
	logic [$bits(result_t)-1:0] m_tdata;
	logic                   cfg_we;
	logic [1:0]             cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// model state
	logic [MASK_W-1:0]      group_mask [3];
	logic [GROUP_W-1:0]     grp_count;
	bit                     phase_q [NUM_SENSORS];
	logic [TS_W-1:0]        start_q [NUM_SENSORS];
	logic [DIST_W-1:0]      dist_q [NUM_SENSORS];
	logic [TALLY_W-1:0]     tally_q [NUM_SENSORS];
	logic [MASK_W-1:0]      wait_mask;
	int                     cur_group;

	result_t                echo_q [$];
	dir_row_t               dir_tab [$];
	int                     errors;
	bit                     stall_on;

	multi_sensor_echo_ranger dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int live_groups();
		int n;
		n = grp_count;
		if (n > GROUP_LIMIT) n = GROUP_LIMIT;
		return n;
	endfunction

	function automatic void next_group();
		int nx;
		nx = cur_group + 1;
		if (nx >= live_groups()) nx = 0;
		cur_group = nx;
	endfunction

	function automatic void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
		REG_GROUP_MASK_0: group_mask[0] = val;
		REG_GROUP_MASK_1: group_mask[1] = val;
		REG_GROUP_MASK_2: group_mask[2] = val;
		REG_GROUP_COUNT:  grp_count = val[GROUP_W-1:0];
		default: ;
		endcase
	endfunction

	function automatic result_t mk_res(bit meas, logic [DIST_W-1:0] dist_val,
			logic [TALLY_W-1:0] tally, logic [MASK_W-1:0] trig,
			logic [MASK_W-1:0] tmask, bit done, logic [GROUP_W-1:0] gi);
		result_t r;
		r.measured      = meas;
		r.distance_um   = dist_val;
		r.timeout_total = tally;
		r.trigger_mask  = trig;
		r.timeout_mask  = tmask;
		r.group_done    = done;
		r.group_index   = gi;
		return r;
	endfunction

	// advances the ranger state by one event and returns the status it reports
	function automatic result_t predict_echo(logic [1:0] k, logic [2:0] sn,
			logic [TS_W-1:0] ts);
		result_t r;
		logic [TS_W-1:0] pulse_w;
		bit ok;
		r = '0;
		ok = (sn < NUM_SENSORS);
		case (k)
		KIND_CAPTURE: begin
			if (ok && !phase_q[sn]) begin
				start_q[sn] = ts;
				phase_q[sn] = 1'b1;
			end else if (ok) begin
				pulse_w = ts - start_q[sn];
				dist_q[sn] = DIST_W'(pulse_w) * DIST_W'(UM_PER_COUNT);
				phase_q[sn] = 1'b0;
				r.measured = 1'b1;
				if (wait_mask[sn]) begin
					wait_mask[sn] = 1'b0;
					if (wait_mask == '0) begin
						next_group();
						r.group_done = 1'b1;
					end
				end
			end
		end
		KIND_TRIGGER: begin
			if (live_groups() != 0) begin
				if (cur_group >= live_groups()) cur_group = 0;
				r.trigger_mask = group_mask[cur_group] & ALL_SENSORS;
				wait_mask = r.trigger_mask;
				if (wait_mask == '0) begin
					next_group();
					r.group_done = 1'b1;
				end
			end
		end
		KIND_TIMEOUT: begin
			if (wait_mask != '0) begin
				r.timeout_mask = wait_mask;
				for (int i = 0; i < NUM_SENSORS; i++) begin
					if (wait_mask[i]) begin
						if (tally_q[i] != TALLY_MAX) tally_q[i]++;
						phase_q[i] = 1'b0;
						start_q[i] = '0;
						dist_q[i] = FAR_DISTANCE;
					end
				end
				wait_mask = '0;
				next_group();
				r.group_done = 1'b1;
			end
		end
		default: ;
		endcase
		if (ok) begin
			r.distance_um = dist_q[sn];
			r.timeout_total = tally_q[sn];
		end
		r.group_index = GROUP_W'(cur_group);
		return r;
	endfunction

	function automatic int draw_gap();
		return stall_on ? $urandom_range(0, 7) : 0;
	endfunction

	task automatic cmp_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_result(result_t got);
		result_t want;
		if (echo_q.size() == 0) begin
			$display("%0t unexpected result transaction: expected none actual %h",
				$time, got);
			errors++;
		end else begin
			want = echo_q.pop_front();
			cmp_field("measured", want.measured, got.measured);
			cmp_field("distance_um", want.distance_um, got.distance_um);
			cmp_field("timeout_total", want.timeout_total, got.timeout_total);
			cmp_field("trigger_mask", want.trigger_mask, got.trigger_mask);
			cmp_field("timeout_mask", want.timeout_mask, got.timeout_mask);
			cmp_field("group_done", want.group_done, got.group_done);
			cmp_field("group_index", want.group_index, got.group_index);
		end
	endtask

	task automatic send_event(logic [1:0] k, logic [2:0] sn, logic [TS_W-1:0] ts,
			bit typed, result_t want);
		int gap;
		result_t pred;
		gap = draw_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, ts, sn};
		s_tuser <= k;
		do @(posedge clk); while (!s_tready);
		pred = predict_echo(k, sn, ts);
		echo_q.push_back(typed ? want : pred);
	endtask

	// registers change only with nothing in flight
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (echo_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, val);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_result(m_tdata);
	end

	// output side: random stall before each result transaction
	initial begin
		int gap;
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			gap = draw_gap();
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [CFG_DATA_W-1:0] cv [4];
		logic [1:0]            k;
		logic [2:0]            sn;
		logic [TS_W-1:0]       ts;
		int                    roll;
		int                    counted;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		errors = 0;
		stall_on = 1'b1;

		group_mask[0] = RST_MASK_0;
		group_mask[1] = RST_MASK_1;
		group_mask[2] = RST_MASK_2;
		grp_count = RST_GROUP_COUNT;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			phase_q[i] = 1'b0;
			start_q[i] = '0;
			dist_q[i] = FAR_DISTANCE;
			tally_q[i] = '0;
		end
		wait_mask = '0;
		cur_group = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, default groups {0,3,5} {1,4} {2}
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd0, 16'd0, 1'b1,
			mk_res(1'b0, FAR_DISTANCE, 16'd0, 6'd0, 6'd0, 1'b0, 2'd0)});
		// widest pulse
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd0, 16'hFFFF, 1'b1,
			mk_res(1'b1, 24'd11140950, 16'd0, 6'd0, 6'd0, 1'b0, 2'd0)});
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd5, 16'd100, 1'b0, '0});
		// falling edge timestamp below the rising one wraps
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd5, 16'd99, 1'b0, '0});
		// out-of-range sensors are ignored
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd6, 16'hFFFF, 1'b1,
			mk_res(1'b0, 24'd0, 16'd0, 6'd0, 6'd0, 1'b0, 2'd0)});
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd7, 16'd0, 1'b1,
			mk_res(1'b0, 24'd0, 16'd0, 6'd0, 6'd0, 1'b0, 2'd0)});
		dir_tab.push_back('{1'b0, KIND_RESERVED, 3'd3, 16'd1234, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_TRIGGER, 3'd0, 16'd0, 1'b1,
			mk_res(1'b0, 24'd11140950, 16'd0, 6'd41, 6'd0, 1'b0, 2'd0)});
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd3, 16'd50, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_TIMEOUT, 3'd3, 16'd0, 1'b1,
			mk_res(1'b0, FAR_DISTANCE, 16'd1, 6'd0, 6'd41, 1'b1, 2'd1)});
		// nothing waiting
		dir_tab.push_back('{1'b0, KIND_TIMEOUT, 3'd0, 16'd0, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_TRIGGER, 3'd1, 16'd0, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd1, 16'd10, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd1, 16'd20, 1'b0, '0});
		// sensor outside the group still measures
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd2, 16'd7, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd2, 16'd8, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd4, 16'd500, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd4, 16'd400, 1'b0, '0});
		// retrigger of the same group
		dir_tab.push_back('{1'b0, KIND_TRIGGER, 3'd2, 16'd0, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_TRIGGER, 3'd2, 16'd0, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd2, 16'd0, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_CAPTURE, 3'd2, 16'hFFFF, 1'b0, '0});
		// full group, then empty group advancing at once
		dir_tab.push_back('{1'b1, REG_GROUP_MASK_1, 3'd0, 16'd0, 1'b0, '0});
		dir_tab.push_back('{1'b1, REG_GROUP_MASK_0, 3'd0, 16'd63, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_TRIGGER, 3'd0, 16'd0, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_TIMEOUT, 3'd4, 16'd0, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_TRIGGER, 3'd1, 16'd0, 1'b0, '0});
		// group index beyond the group count wraps before the trigger
		dir_tab.push_back('{1'b1, REG_GROUP_COUNT, 3'd0, 16'd1, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_TRIGGER, 3'd2, 16'd0, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_TIMEOUT, 3'd5, 16'd0, 1'b0, '0});
		// no groups: trigger does nothing
		dir_tab.push_back('{1'b1, REG_GROUP_COUNT, 3'd0, 16'd0, 1'b0, '0});
		dir_tab.push_back('{1'b0, KIND_TRIGGER, 3'd0, 16'd0, 1'b0, '0});
		dir_tab.push_back('{1'b1, REG_GROUP_MASK_2, 3'd0, 16'd63, 1'b0, '0});

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				wait_idle();
				cfg_write(cfg_reg_t'(dir_tab[i].code), dir_tab[i].value[CFG_DATA_W-1:0]);
			end else begin
				send_event(dir_tab[i].code, dir_tab[i].sensor, dir_tab[i].value,
					dir_tab[i].typed, dir_tab[i].want);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			if (ph == 0) cv = '{6'd63, 6'd0, 6'd63, 6'd0};
			else if (ph == 1) cv = '{6'd63, 6'd63, 6'd63, 6'd3};
			else if (ph == 2) cv = '{6'd0, 6'd0, 6'd0, 6'd2};
			else begin
				for (int j = 0; j < 3; j++) begin
					roll = $urandom_range(0, 7);
					cv[j] = (roll == 0) ? 6'd0 : (roll == 1) ? 6'd63 : 6'($urandom);
				end
				cv[3] = 6'($urandom_range(1, 3));
			end
			cfg_write(REG_GROUP_MASK_0, cv[0]);
			cfg_write(REG_GROUP_MASK_1, cv[1]);
			cfg_write(REG_GROUP_MASK_2, cv[2]);
			cfg_write(REG_GROUP_COUNT, cv[3]);
			stall_on = (ph % 3 != 2);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				roll = $urandom_range(0, 99);
				k = KIND_CAPTURE;
				sn = 3'($urandom_range(0, 5));
				ts = 16'($urandom);
				counted++;
				if (wait_mask != '0 && roll < 45) begin
					do sn = 3'($urandom_range(0, 5)); while (!wait_mask[sn]);
				end else if (roll < 57) begin
					k = KIND_TRIGGER;
					sn = 3'($urandom_range(0, 7));
				end else if (roll < 65) begin
					k = KIND_TIMEOUT;
					sn = 3'($urandom_range(0, 7));
				end else if (roll < 70) begin
					k = KIND_RESERVED;
					sn = 3'($urandom_range(0, 7));
					counted--;
				end else if (roll < 75) begin
					sn = 3'($urandom_range(6, 7));
					counted--;
				end
				// falling edge: mostly short pulses, some of any width
				if (k == KIND_CAPTURE && sn < NUM_SENSORS && phase_q[sn])
					ts = start_q[sn] + (($urandom_range(0, 3) == 0) ?
						16'($urandom) : 16'($urandom_range(0, 3000)));
				send_event(k, sn, ts, 1'b0, '0);
			end
		end
		stall_on = 1'b1;

		s_tvalid <= 1'b0;
		while (echo_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
